FILE: src/hmr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Hashed message router package
// Shared types and constants for the router.
// ----------------------------------------------------------------------------
package hmr_pkg;

	localparam int SLOTS        = 16;
	localparam int ID_MAX       = 128;
	localparam int BODY_MAX     = 1024;
	localparam int WORKER_COUNT = 8;

	localparam int SLOT_W = 4;
	localparam int IDL_W  = $clog2(ID_MAX + 1);
	localparam int BDL_W  = $clog2(BODY_MAX + 1);
	localparam int IDA_W  = $clog2(SLOTS * ID_MAX);
	localparam int BDA_W  = $clog2(SLOTS * BODY_MAX);
	localparam int WK_W   = (WORKER_COUNT > 1) ? $clog2(WORKER_COUNT) : 1;

	localparam logic [8:0] TAG_NONE = 9'h100;

	typedef enum logic [1:0] {
		FUNC_BYTE  = 2'd0,
		FUNC_OPEN  = 2'd1,
		FUNC_CLOSE = 2'd2,
		FUNC_READ  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_REG  = 2'd1,
		PH_ID   = 2'd2,
		PH_BODY = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		KIND_FORWARD = 3'd0,
		KIND_DROP    = 3'd1,
		KIND_REG     = 3'd2,
		KIND_FRAME   = 3'd3,
		KIND_OVERRUN = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_EXEC  = 2'd1,
		ST_SCAN  = 2'd2,
		ST_OUT   = 2'd3
	} state_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [3:0]  slot;
		logic [7:0]  data_byte;
		logic [10:0] frame_offset;
	} req_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  dest_slot;
		logic [7:0]  worker_number;
		logic [3:0]  source_slot;
		logic [10:0] frame_length;
		logic [7:0]  frame_byte;
	} rsp_t;

endpackage
`default_nettype wire

FILE: src/hashed_message_router.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Hashed message router
// Per-slot command parser with hash-based worker selection and frame readback.
// ----------------------------------------------------------------------------
// An open, close, ignored byte or stored byte passes through the execute state
// only; a frame read goes on to an output state for its byte-store read, and
// a body close goes on to a worker search that walks the slot table one slot
// per cycle. One request is in work at a time; the result waits in an output
// register and the next request is taken once it has been handed over.
module hashed_message_router
	import hmr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire req_t in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output rsp_t      out_data
);

	state_t st_q, st_d;
	req_t   req_q;

	logic [SLOTS-1:0]   open_q;
	phase_t             ph_q   [SLOTS];
	logic [8:0]         tag_q  [SLOTS];
	logic [IDL_W-1:0]   idl_q  [SLOTS];
	logic [BDL_W-1:0]   bdl_q  [SLOTS];
	logic [31:0]        hash_q [SLOTS];

	logic [SLOT_W-1:0]  scan_q;
	logic [7:0]         wk_q;
	logic [10:0]        len_q;
	rsp_t               rsp_q;
	rsp_t               rsp_x;
	logic               ov_q;

	logic [3:0]         s;
	logic [7:0]         b;
	logic [10:0]        flen;
	logic [11:0]        off, offb;
	logic               id_we, bd_we;
	logic [IDA_W-1:0]   id_wa, id_ra;
	logic [BDA_W-1:0]   bd_wa, bd_ra;
	logic [7:0]         id_rd, bd_rd;
	logic               use_id, use_bd;
	logic               slot_ok;
	logic               hit;

	assign s    = req_q.slot;
	assign b    = req_q.data_byte;
	assign slot_ok = ({1'b0, s} < 5'(SLOTS));
	assign flen = 11'(idl_q[s]) + 11'(bdl_q[s]) + 11'd3;
	assign off  = {1'b0, req_q.frame_offset} - 12'd1;
	assign offb = off - 12'(idl_q[s]) - 12'd1;
	assign hit  = open_q[scan_q] && (tag_q[scan_q] == {1'b0, wk_q});

	assign in_ready  = (st_q == ST_IDLE) && !ov_q;
	assign out_valid = ov_q;
	assign out_data  = rsp_q;

	always_comb begin
		id_we = 1'b0;
		bd_we = 1'b0;
		if (st_q == ST_EXEC && slot_ok && req_q.func == FUNC_BYTE && open_q[s] && b != 8'd0) begin
			id_we = (ph_q[s] == PH_ID) && (idl_q[s] < IDL_W'(ID_MAX));
			bd_we = (ph_q[s] == PH_BODY) && (bdl_q[s] < BDL_W'(BODY_MAX));
		end
	end
	assign id_wa = {s, idl_q[s][IDA_W-SLOT_W-1:0]};
	assign bd_wa = {s, bdl_q[s][BDA_W-SLOT_W-1:0]};
	assign id_ra = {s, off[IDA_W-SLOT_W-1:0]};
	assign bd_ra = {s, offb[BDA_W-SLOT_W-1:0]};

	hmr_byte_ram #(.AW(IDA_W)) u_id_ram (
		.clk(clk), .we(id_we), .waddr(id_wa), .wdata(b), .raddr(id_ra), .rdata(id_rd)
	);
	hmr_byte_ram #(.AW(BDA_W)) u_bd_ram (
		.clk(clk), .we(bd_we), .waddr(bd_wa), .wdata(b), .raddr(bd_ra), .rdata(bd_rd)
	);

	assign use_id = (off < 12'(idl_q[s]));
	assign use_bd = !use_id && offb != 12'hfff && (offb < 12'(bdl_q[s]));

	always_comb begin
		rsp_x = '0;
		rsp_x.source_slot = s;
		case (st_q)
			ST_EXEC: begin
				if (req_q.func == FUNC_READ) begin
					rsp_x.kind = KIND_FRAME;
				end else if (ph_q[s] == PH_REG) begin
					rsp_x.kind = KIND_REG;
					rsp_x.worker_number = b;
				end else begin
					rsp_x.kind = KIND_OVERRUN;
				end
			end
			ST_SCAN: begin
				rsp_x.kind = hit ? KIND_FORWARD : KIND_DROP;
				rsp_x.dest_slot = hit ? scan_q : '0;
				rsp_x.worker_number = wk_q;
				rsp_x.frame_length = len_q;
			end
			ST_OUT: begin
				rsp_x.kind = KIND_FRAME;
				rsp_x.frame_length = len_q;
				if (req_q.frame_offset == 11'd0) begin
					rsp_x.frame_byte = 8'd2;
				end else if (req_q.frame_offset >= len_q) begin
					rsp_x.frame_byte = 8'd0;
				end else if (use_id) begin
					rsp_x.frame_byte = id_rd;
				end else if (use_bd) begin
					rsp_x.frame_byte = bd_rd;
				end else begin
					rsp_x.frame_byte = 8'd0;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					st_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (slot_ok && req_q.func == FUNC_BYTE && open_q[s] && ph_q[s] == PH_BODY
						&& b == 8'd0) begin
					st_d = ST_SCAN;
				end else if (slot_ok && req_q.func == FUNC_READ) begin
					st_d = ST_OUT;
				end else begin
					st_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (hit || scan_q == SLOT_W'(SLOTS - 1)) begin
					st_d = ST_IDLE;
				end
			end
			ST_OUT:  st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			ov_q   <= 1'b0;
			req_q  <= '0;
			scan_q <= '0;
			wk_q   <= '0;
			len_q  <= '0;
			rsp_q  <= '0;
			open_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				ph_q[i]   <= PH_IDLE;
				tag_q[i]  <= TAG_NONE;
				idl_q[i]  <= '0;
				bdl_q[i]  <= '0;
				hash_q[i] <= '0;
			end
		end else begin
			st_q <= st_d;
			if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
			if (st_q != ST_IDLE) begin
				rsp_q <= rsp_x;
			end
			case (st_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						req_q <= in_data;
					end
				end
				ST_EXEC: begin
					if (!slot_ok) begin
						if (req_q.func == FUNC_READ) begin
							ov_q <= 1'b1;
						end
					end else begin
						case (func_t'(req_q.func))
							FUNC_OPEN: begin
								open_q[s] <= 1'b1;
								ph_q[s]   <= PH_IDLE;
								tag_q[s]  <= TAG_NONE;
								idl_q[s]  <= '0;
								bdl_q[s]  <= '0;
								hash_q[s] <= '0;
							end
							FUNC_CLOSE: open_q[s] <= 1'b0;
							FUNC_READ: begin
								len_q <= flen;
							end
							default: begin
								if (open_q[s]) begin
									case (ph_q[s])
										PH_IDLE: begin
											if (b == 8'd1) begin
												ph_q[s] <= PH_REG;
											end else if (b == 8'd2) begin
												ph_q[s]   <= PH_ID;
												idl_q[s]  <= '0;
												bdl_q[s]  <= '0;
												hash_q[s] <= '0;
											end
										end
										PH_REG: begin
											tag_q[s] <= {1'b0, b};
											ph_q[s]  <= PH_IDLE;
											ov_q <= 1'b1;
										end
										PH_ID: begin
											if (b == 8'd0) begin
												ph_q[s] <= PH_BODY;
											end else if (id_we) begin
												idl_q[s]  <= idl_q[s] + 1'b1;
												hash_q[s] <= hash_q[s] * 32'd31 + 32'(b);
											end else begin
												ov_q <= 1'b1;
											end
										end
										default: begin
											if (b == 8'd0) begin
												ph_q[s] <= PH_IDLE;
												scan_q  <= '0;
												wk_q    <= 8'(hash_q[s] % 32'(WORKER_COUNT));
												len_q   <= flen;
											end else if (bd_we) begin
												bdl_q[s] <= bdl_q[s] + 1'b1;
											end else begin
												ov_q <= 1'b1;
											end
										end
									endcase
								end
							end
						endcase
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (hit || scan_q == SLOT_W'(SLOTS - 1)) begin
						ov_q <= 1'b1;
					end
				end
				ST_OUT: begin
					ov_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> !in_ready) else $error("accept while busy");
	a_scan_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SCAN) |-> !out_valid) else $error("output during scan");
	a_exec_after_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (st_q == ST_EXEC)) else $error("no exec");

endmodule
`default_nettype wire

FILE: src/hmr_byte_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Byte store RAM
// Single-port-write, single-read byte memory with a registered read.
// ----------------------------------------------------------------------------
module hmr_byte_ram #(
	parameter int AW = 8
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire
